### rtl/strided_conv2d_engine_macros.svh
// ----------------------------------------------------------------------------
// Strided convolution engine assertion macros
// Assertion wrappers included by the engine top-level file.
// ----------------------------------------------------------------------------
`ifndef STRIDED_CONV2D_ENGINE_MACROS_SVH
`define STRIDED_CONV2D_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF
`define SC2E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SC2E_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SC2E_ASSERT(lbl, prop, msg)
`define SC2E_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/sc2e_pkg.sv
// ----------------------------------------------------------------------------
// Strided convolution engine package
// Transaction types, function and status codes and register indexes.
// ----------------------------------------------------------------------------
package sc2e_pkg;

  localparam int unsigned COORD_W = 9;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned ACC_W = 48;

  localparam logic [1:0] FUNC_WR_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_WR_WEIGHT = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE   = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SAT   = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE  = 3'd4;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         in_chan;
    logic [3:0]         out_chan;
    logic [5:0]         row;
    logic [5:0]         col;
    logic [2:0]         krow;
    logic [2:0]         kcol;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctrl_t;

endpackage

### rtl/sc2e_mac.sv
// ----------------------------------------------------------------------------
// Strided convolution engine multiply-accumulate unit
// Registered 16 x 16 signed product followed by a 48-bit accumulator.
// ----------------------------------------------------------------------------
module sc2e_mac (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sc2e_pkg::mac_ctrl_t         ctrl_i,
  input  logic signed [15:0]          samp_i,
  input  logic signed [15:0]          wgt_i,
  output logic signed [sc2e_pkg::ACC_W-1:0] acc_o
);
  import sc2e_pkg::*;

  logic signed [31:0]      prod_q;
  logic                    prod_vld_q;
  logic signed [ACC_W-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.vld;
      if (ctrl_i.clr) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + {{(ACC_W-32){prod_q[31]}}, prod_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= samp_i * wgt_i;
  end

  assign acc_o = acc_q;

endmodule

### rtl/strided_conv2d_engine.sv
// ----------------------------------------------------------------------------
// Strided convolution engine
// Stride-2, zero-padded 2-D convolution over stored samples and weights.
// ----------------------------------------------------------------------------
// A compute transaction walks every input channel and kernel tap through one
// shared multiply-accumulate unit, one tap per cycle, and occupies the engine
// until its result is registered at the output; a compute whose output
// coordinate is out of range skips the taps and goes straight to the finish
// state. Input is stalled while a compute runs. The sample and weight
// memories are not cleared at reset and must be written before they are used.
`include "strided_conv2d_engine_macros.svh"

module strided_conv2d_engine #(
  parameter int unsigned MAX_HEIGHT       = 64,
  parameter int unsigned MAX_WIDTH        = 64,
  parameter int unsigned MAX_IN_CHANNELS  = 16,
  parameter int unsigned MAX_OUT_CHANNELS = 16,
  parameter int unsigned MAX_KERNEL       = 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  sc2e_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output sc2e_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [sc2e_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [sc2e_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import sc2e_pkg::*;

  localparam int unsigned MAP_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int unsigned WGT_DEPTH =
    MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int unsigned MAP_AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int unsigned WGT_AW = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int unsigned H_RST  = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;
  localparam int unsigned W_RST  = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
  localparam int unsigned IC_RST = (MAX_IN_CHANNELS < 16) ? MAX_IN_CHANNELS : 16;
  localparam int unsigned OC_RST = (MAX_OUT_CHANNELS < 16) ? MAX_OUT_CHANNELS : 16;
  localparam int unsigned K_RST  = (MAX_KERNEL < 5) ? MAX_KERNEL : 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e state_q;

  logic [6:0] in_height_q, in_width_q;
  logic [4:0] in_channels_q, out_channels_q;
  logic [2:0] kernel_size_q;

  logic [3:0] oc_q;
  logic [5:0] row_q, col_q;
  logic [4:0] ci_q;
  logic [2:0] a_q, b_q;
  logic       bad_q;
  logic       drain_q;
  logic       tap_vld_q;
  logic       out_valid_q;
  out_item_t  out_data_q;

  logic signed [15:0] map_mem [MAP_DEPTH];
  logic signed [15:0] wgt_mem [WGT_DEPTH];
  logic signed [15:0] samp_q, wgt_q;

  logic                    in_acc;
  logic                    start_compute;
  logic [6:0]              out_h, out_w;
  logic                    coord_bad;
  logic [2:0]              pad;
  logic [2:0]              k_last;
  logic                    last_tap;
  logic signed [COORD_W-1:0] hi_s, wi_s;
  logic                    tap_ok;
  logic [MAP_AW-1:0]       map_raddr, map_waddr;
  logic [WGT_AW-1:0]       wgt_raddr, wgt_waddr;
  logic                    map_we, wgt_we;
  mac_ctrl_t               mac_ctrl;
  logic signed [ACC_W-1:0] acc;
  logic                    sat_hi, sat_lo;
  out_item_t               result;

  assign in_acc        = in_valid_i && !in_stall_o;
  assign start_compute = in_acc && (in_data_i.func == FUNC_COMPUTE);
  assign in_stall_o    = (state_q != ST_IDLE);

  // Output extent: floor((size - k) / 2) + 1, or zero when the map is too small.
  always_comb begin
    out_h = '0;
    out_w = '0;
    if (in_height_q >= {4'd0, kernel_size_q}) begin
      out_h = ((in_height_q - {4'd0, kernel_size_q}) >> 1) + 7'd1;
    end
    if (in_width_q >= {4'd0, kernel_size_q}) begin
      out_w = ((in_width_q - {4'd0, kernel_size_q}) >> 1) + 7'd1;
    end
  end

  assign coord_bad = ({1'b0, in_data_i.out_chan} >= out_channels_q) ||
                     ({1'b0, in_data_i.row} >= out_h) ||
                     ({1'b0, in_data_i.col} >= out_w);

  assign pad      = kernel_size_q >> 1;
  assign k_last   = kernel_size_q - 3'd1;
  assign last_tap = (ci_q == in_channels_q - 5'd1) && (a_q == k_last) && (b_q == k_last);

  assign hi_s = $signed({2'b00, row_q, 1'b0}) + $signed({6'd0, a_q}) - $signed({6'd0, pad});
  assign wi_s = $signed({2'b00, col_q, 1'b0}) + $signed({6'd0, b_q}) - $signed({6'd0, pad});

  assign tap_ok = !hi_s[COORD_W-1] && !wi_s[COORD_W-1] &&
                  (hi_s < $signed({2'b00, in_height_q})) &&
                  (wi_s < $signed({2'b00, in_width_q}));

  assign map_raddr = (MAP_AW'(ci_q) * MAP_AW'(MAX_HEIGHT) + MAP_AW'(hi_s[7:0]))
                     * MAP_AW'(MAX_WIDTH) + MAP_AW'(wi_s[7:0]);
  assign wgt_raddr = ((WGT_AW'(oc_q) * WGT_AW'(MAX_IN_CHANNELS) + WGT_AW'(ci_q))
                      * WGT_AW'(MAX_KERNEL) + WGT_AW'(a_q)) * WGT_AW'(MAX_KERNEL)
                     + WGT_AW'(b_q);

  assign map_waddr = (MAP_AW'(in_data_i.in_chan) * MAP_AW'(MAX_HEIGHT)
                      + MAP_AW'(in_data_i.row)) * MAP_AW'(MAX_WIDTH)
                     + MAP_AW'(in_data_i.col);
  assign wgt_waddr = ((WGT_AW'(in_data_i.out_chan) * WGT_AW'(MAX_IN_CHANNELS)
                       + WGT_AW'(in_data_i.in_chan)) * WGT_AW'(MAX_KERNEL)
                      + WGT_AW'(in_data_i.krow)) * WGT_AW'(MAX_KERNEL)
                     + WGT_AW'(in_data_i.kcol);

  assign map_we = in_acc && (in_data_i.func == FUNC_WR_SAMPLE) &&
                  (32'(in_data_i.in_chan) < MAX_IN_CHANNELS) &&
                  (32'(in_data_i.row) < MAX_HEIGHT) &&
                  (32'(in_data_i.col) < MAX_WIDTH);
  assign wgt_we = in_acc && (in_data_i.func == FUNC_WR_WEIGHT) &&
                  (32'(in_data_i.out_chan) < MAX_OUT_CHANNELS) &&
                  (32'(in_data_i.in_chan) < MAX_IN_CHANNELS) &&
                  (32'(in_data_i.krow) < MAX_KERNEL) &&
                  (32'(in_data_i.kcol) < MAX_KERNEL);

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= in_data_i.value;
    end
    samp_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wgt_we) begin
      wgt_mem[wgt_waddr] <= in_data_i.value;
    end
    wgt_q <= wgt_mem[wgt_raddr];
  end

  assign mac_ctrl.clr = start_compute;
  assign mac_ctrl.vld = tap_vld_q;

  sc2e_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .samp_i (samp_q),
    .wgt_i  (wgt_q),
    .acc_o  (acc)
  );

  assign sat_hi = !acc[ACC_W-1] && (|acc[ACC_W-2:31]);
  assign sat_lo = acc[ACC_W-1] && !(&acc[ACC_W-2:31]);

  always_comb begin
    result.out_value = acc[31:0];
    result.status    = STATUS_OK;
    if (bad_q) begin
      result.out_value = '0;
      result.status    = STATUS_RANGE;
    end else if (sat_hi) begin
      result.out_value = 32'sh7FFF_FFFF;
      result.status    = STATUS_SAT;
    end else if (sat_lo) begin
      result.out_value = 32'sh8000_0000;
      result.status    = STATUS_SAT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      in_height_q    <= 7'(H_RST);
      in_width_q     <= 7'(W_RST);
      in_channels_q  <= 5'(IC_RST);
      out_channels_q <= 5'(OC_RST);
      kernel_size_q  <= 3'(K_RST);
      oc_q           <= '0;
      row_q          <= '0;
      col_q          <= '0;
      ci_q           <= '0;
      a_q            <= '0;
      b_q            <= '0;
      bad_q          <= 1'b0;
      drain_q        <= 1'b0;
      tap_vld_q      <= 1'b0;
      out_valid_q    <= 1'b0;
      out_data_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_IN_HEIGHT: begin
            in_height_q <= (cfg_wdata_i == '0) ? 7'd1 :
                           (32'(cfg_wdata_i) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : cfg_wdata_i;
          end
          REG_IN_WIDTH: begin
            in_width_q <= (cfg_wdata_i == '0) ? 7'd1 :
                          (32'(cfg_wdata_i) > MAX_WIDTH) ? 7'(MAX_WIDTH) : cfg_wdata_i;
          end
          REG_IN_CHANNELS: begin
            in_channels_q <= (cfg_wdata_i[4:0] == '0) ? 5'd1 :
                             (32'(cfg_wdata_i[4:0]) > MAX_IN_CHANNELS) ?
                             5'(MAX_IN_CHANNELS) : cfg_wdata_i[4:0];
          end
          REG_OUT_CHANNELS: begin
            out_channels_q <= (cfg_wdata_i[4:0] == '0) ? 5'd1 :
                              (32'(cfg_wdata_i[4:0]) > MAX_OUT_CHANNELS) ?
                              5'(MAX_OUT_CHANNELS) : cfg_wdata_i[4:0];
          end
          REG_KERNEL_SIZE: begin
            kernel_size_q <= (cfg_wdata_i[2:0] == '0) ? 3'd1 :
                             (32'(cfg_wdata_i[2:0]) > MAX_KERNEL) ?
                             3'(MAX_KERNEL) : cfg_wdata_i[2:0];
          end
          default: begin
          end
        endcase
      end

      // In the finish state the output register is refilled below instead.
      if (out_valid_q && !out_stall_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      tap_vld_q <= (state_q == ST_RUN) && tap_ok;

      unique case (state_q)
        ST_IDLE: begin
          if (start_compute) begin
            oc_q  <= in_data_i.out_chan;
            row_q <= in_data_i.row;
            col_q <= in_data_i.col;
            ci_q  <= '0;
            a_q   <= '0;
            b_q   <= '0;
            bad_q <= coord_bad;
            state_q <= coord_bad ? ST_FINISH : ST_RUN;
          end
        end
        ST_RUN: begin
          if (b_q == k_last) begin
            b_q <= '0;
            if (a_q == k_last) begin
              a_q  <= '0;
              ci_q <= ci_q + 5'd1;
            end else begin
              a_q <= a_q + 3'd1;
            end
          end else begin
            b_q <= b_q + 3'd1;
          end
          if (last_tap) begin
            drain_q <= 1'b0;
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain_q <= 1'b1;
          if (drain_q) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= result;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SC2E_ASSERT(a_result_from_finish, $rose(out_valid_q) |-> $past(state_q == ST_FINISH), "result raised outside the finish state")
  `SC2E_ASSERT(a_pipe_empty_at_finish, (state_q == ST_FINISH) |-> !tap_vld_q, "tap still in flight when the sum is taken")
  `SC2E_ASSERT(a_compute_leaves_idle, start_compute |=> (state_q != ST_IDLE), "compute transaction did not start the sequencer")
  `SC2E_ASSERT_ALWAYS(a_range_result_zero, (out_valid_q && out_data_q.status == STATUS_RANGE) |-> (out_data_q.out_value == '0), "out-of-range result carries a non-zero value")

endmodule
